### rtl/core/rfa_pkg.sv
// Package for the rational fraction ALU: operation codes, controller states
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none
package rfa_pkg;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_TRN = 3'd4;

  // Sources for the shared divider operands and the multiplier operands
  typedef enum logic [1:0] {
    DSRC_EUCLID = 2'd0,
    DSRC_XY     = 2'd1,
    DSRC_T1     = 2'd2,
    DSRC_T2     = 2'd3
  } dsrc_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_EUC_START,
    ST_EUC_WAIT,
    ST_LCM_PREP,
    ST_LCM_START,
    ST_LCM_WAIT,
    ST_T1_PREP,
    ST_T1_START,
    ST_T1_WAIT,
    ST_T2_PREP,
    ST_T2_START,
    ST_T2_WAIT,
    ST_FIN,
    ST_TRN_START,
    ST_TRN_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic  load;       // capture operands
    logic  order;      // choose larger/smaller from denominators
    logic  div_start;  // launch divider
    dsrc_t div_src;
    logic  trn_sel;    // divider takes a_num / a_den
    logic  euc_step;   // shift sml->big, rem->sml
    logic  set_m_big;  // m <= big
    logic  set_m_q;    // m <= quotient
    logic  set_t1;
    logic  set_t2;
    logic  fin_addsub;
    logic  fin_trn;
    logic  fin_mul;
    logic  fin_err;
    logic  fin_zero;
  } rfa_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       ad_zero;
    logic       bd_zero;
    logic       rem_zero;
    logic       div_done;
  } rfa_stat_t;

endpackage
`default_nettype wire

### rtl/core/rational_fraction_alu_unit.sv
// Top level of the rational fraction ALU: controller plus datapath.
// Uses rfa_pkg, rfa_ctrl, rfa_datapath (and through it rfa_divider).
//
// Usage: present kind and the fractions a_num/a_den, b_num/b_den with
// in_valid; a transfer happens on a clock edge with in_valid high and
// in_stall low. One item is worked at a time; in_stall stays high until
// its result has been transferred on the output channel (out_valid,
// out_stall). The result holds steady while out_stall is high.
// Multiply, divide, unused kinds and zero divisors go straight from
// dispatch to the output; truncate takes one divider pass. Add/subtract
// take S Euclid remainder passes, then a common-multiple division when
// S > 1, then one division for each term; S reaches about 46 at W=32
// (W = WORD_BITS). After the result transfer the controller returns to
// idle before the next input transfer can happen. The shared bit-serial
// divider sets the rate.
// Synchronous reset returns the controller to idle; no result is pending.
`default_nettype none
module rational_fraction_alu_unit #(
  parameter int WORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  kind,
  input  wire logic [31:0] a_num,
  input  wire logic [31:0] a_den,
  input  wire logic [31:0] b_num,
  input  wire logic [31:0] b_den,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      res_num,
  output logic [31:0]      res_den,
  output logic             error
);
  import rfa_pkg::*;

  rfa_cmd_t  cmd;
  rfa_stat_t stat;

  rfa_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .stat(stat), .cmd(cmd)
  );

  rfa_datapath #(.W(WORD_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .kind(kind), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .res_num(res_num), .res_den(res_den), .error(error)
  );
endmodule
`default_nettype wire

### rtl/core/rfa_divider.sv
// Iterative truncating signed divider, one quotient bit per cycle.
// Depends on nothing but its ports; divisor assumed nonzero.
`default_nettype none
module rfa_divider #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] num,
  input  wire logic [W-1:0] den,
  output logic              done,
  output logic [W-1:0]      quo,
  output logic [W-1:0]      rem
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q;
  logic [W-1:0]  r;
  logic [W-1:0]  d;
  logic          nq;
  logic          nr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    trial;
  logic [W:0]    diff;

  assign trial = {r, q[W-1]};
  assign diff  = trial - {1'b0, d};

  // Shift-subtract restoring division on magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        q    <= num[W-1] ? -num : num;
        d    <= den[W-1] ? -den : den;
        r    <= '0;
        nq   <= num[W-1] ^ den[W-1];
        nr   <= num[W-1];
      end else if (busy) begin
        if (!diff[W]) begin
          r <= diff[W-1:0];
          q <= {q[W-2:0], 1'b1};
        end else begin
          r <= trial[W-1:0];
          q <= {q[W-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = nq ? -q : q;
  assign rem = nr ? -r : r;
endmodule
`default_nettype wire

### rtl/core/rfa_datapath.sv
// Datapath of the fraction ALU: operand, Euclid and result registers,
// the shared divider and the multipliers. Uses rfa_pkg and rfa_divider.
`default_nettype none
module rfa_datapath #(
  parameter int W = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire rfa_pkg::rfa_cmd_t cmd,
  output rfa_pkg::rfa_stat_t   stat,
  input  wire logic [2:0]      kind,
  input  wire logic [31:0]     a_num,
  input  wire logic [31:0]     a_den,
  input  wire logic [31:0]     b_num,
  input  wire logic [31:0]     b_den,
  output logic [31:0]          res_num,
  output logic [31:0]          res_den,
  output logic                 error
);
  import rfa_pkg::*;

  logic [2:0]   k;
  logic [W-1:0] an, ad, bn, bd;
  logic [W-1:0] big, sml, m, t1, t2;
  logic [W-1:0] dnum, dden, quo, rem;
  logic [W-1:0] diff;
  logic [W-1:0] mul_a, mul_b, mul_p;
  logic         dv_done;
  logic [W-1:0] rn, rd;

  // Sign-extend or truncate a 32-bit field to the working width
  function automatic logic [W-1:0] fext(input logic [31:0] v);
    logic signed [63:0] s;
    s = 64'($signed(v));
    return s[W-1:0];
  endfunction

  function automatic logic [31:0] fout(input logic [W-1:0] v);
    logic signed [63:0] s;
    s = 64'($signed(v));
    return s[31:0];
  endfunction

  assign diff = ad - bd;

  // Divider operand selection
  always_comb begin
    dnum = big;
    dden = sml;
    if (cmd.trn_sel) begin
      dnum = an;
      dden = ad;
    end else begin
      case (cmd.div_src)
        DSRC_EUCLID: begin dnum = big;   dden = sml; end
        DSRC_XY:     begin dnum = mul_p; dden = sml; end
        DSRC_T1:     begin dnum = mul_p; dden = ad;  end
        DSRC_T2:     begin dnum = mul_p; dden = bd;  end
        default:     begin dnum = big;   dden = sml; end
      endcase
    end
  end

  // Multiplier operands: x*y for the lcm, m*an and m*bn for the terms
  always_comb begin
    mul_a = ad;
    mul_b = bd;
    case (cmd.div_src)
      DSRC_XY: begin mul_a = ad; mul_b = bd; end
      DSRC_T1: begin mul_a = m;  mul_b = an; end
      DSRC_T2: begin mul_a = m;  mul_b = bn; end
      default: begin mul_a = ad; mul_b = bd; end
    endcase
  end

  // Registered product so divider operands come from a register
  always_ff @(posedge clk) mul_p <= mul_a * mul_b;

  rfa_divider #(.W(W)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .num(dnum), .den(dden), .done(dv_done), .quo(quo), .rem(rem)
  );

  // Operand and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k  <= kind;
      an <= fext(a_num);
      ad <= fext(a_den);
      bn <= fext(b_num);
      bd <= fext(b_den);
    end
    if (cmd.order) begin
      if (diff != '0 && !diff[W-1]) begin
        big <= ad;
        sml <= bd;
      end else begin
        big <= bd;
        sml <= ad;
      end
    end
    if (cmd.euc_step) begin
      big <= sml;
      sml <= rem;
    end
    if (cmd.set_m_big) m <= big;
    if (cmd.set_m_q)   m <= quo;
    if (cmd.set_t1)    t1 <= quo;
    if (cmd.set_t2)    t2 <= quo;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.fin_addsub) begin
      rn    <= (k == KIND_ADD) ? t1 + t2 : t1 - t2;
      rd    <= m;
      error <= 1'b0;
    end
    if (cmd.fin_trn) begin
      rn    <= quo;
      rd    <= W'(1);
      error <= 1'b0;
    end
    if (cmd.fin_mul) begin
      if (k == KIND_MUL) begin
        rn <= an * bn;
        rd <= ad * bd;
      end else begin
        rn <= an * bd;
        rd <= ad * bn;
      end
      error <= 1'b0;
    end
    if (cmd.fin_err) begin
      rn    <= '0;
      rd    <= '0;
      error <= 1'b1;
    end
    if (cmd.fin_zero) begin
      rn    <= '0;
      rd    <= '0;
      error <= 1'b0;
    end
  end

  assign res_num = fout(rn);
  assign res_den = fout(rd);

  assign stat.kind     = k;
  assign stat.ad_zero  = (ad == '0);
  assign stat.bd_zero  = (bd == '0);
  assign stat.rem_zero = (rem == '0);
  assign stat.div_done = dv_done;
endmodule
`default_nettype wire

### rtl/core/rfa_ctrl.sv
// Controller state machine of the fraction ALU: sequences the Euclid loop,
// the divisions and the handshakes. Uses rfa_pkg.
`default_nettype none
module rfa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire rfa_pkg::rfa_stat_t stat,
  output rfa_pkg::rfa_cmd_t      cmd
);
  import rfa_pkg::*;

  state_t state;
  state_t state_next;
  logic   euc_first;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Mark the first Euclid pass: a zero remainder there makes the larger
  // denominator the common multiple
  always_ff @(posedge clk) begin
    if (rst) euc_first <= 1'b0;
    else if (state == ST_DISPATCH) euc_first <= 1'b1;
    else if (state == ST_EUC_WAIT && stat.div_done && !stat.rem_zero) euc_first <= 1'b0;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (stat.kind) inside
          KIND_ADD, KIND_SUB:
            state_next = (stat.ad_zero || stat.bd_zero) ? ST_OUT : ST_EUC_START;
          KIND_MUL, KIND_DIV: state_next = ST_OUT;
          KIND_TRN:           state_next = stat.ad_zero ? ST_OUT : ST_TRN_START;
          default:            state_next = ST_OUT;
        endcase
      end
      ST_EUC_START: state_next = ST_EUC_WAIT;
      ST_EUC_WAIT: begin
        if (stat.div_done) begin
          if (!stat.rem_zero) state_next = ST_EUC_START;
          else if (euc_first) state_next = ST_T1_PREP;
          else                state_next = ST_LCM_PREP;
        end
      end
      ST_LCM_PREP:  state_next = ST_LCM_START;
      ST_LCM_START: state_next = ST_LCM_WAIT;
      ST_LCM_WAIT:  if (stat.div_done) state_next = ST_T1_PREP;
      ST_T1_PREP:   state_next = ST_T1_START;
      ST_T1_START:  state_next = ST_T1_WAIT;
      ST_T1_WAIT:   if (stat.div_done) state_next = ST_T2_PREP;
      ST_T2_PREP:   state_next = ST_T2_START;
      ST_T2_START:  state_next = ST_T2_WAIT;
      ST_T2_WAIT:   if (stat.div_done) state_next = ST_FIN;
      ST_FIN:       state_next = ST_OUT;
      ST_TRN_START: state_next = ST_TRN_WAIT;
      ST_TRN_WAIT:  if (stat.div_done) state_next = ST_OUT;
      ST_OUT:       if (!out_stall) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Outputs: the PREP states load the product register in the cycle before
  // the divider takes it
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_DISPATCH: begin
        cmd.order = 1'b1;
        unique case (stat.kind) inside
          KIND_ADD, KIND_SUB: cmd.fin_err = stat.ad_zero || stat.bd_zero;
          KIND_MUL, KIND_DIV: cmd.fin_mul = 1'b1;
          KIND_TRN:           cmd.fin_err = stat.ad_zero;
          default:            cmd.fin_zero = 1'b1;
        endcase
      end
      ST_EUC_START: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DSRC_EUCLID;
      end
      ST_EUC_WAIT: begin
        cmd.div_src = DSRC_EUCLID;
        if (stat.div_done) begin
          if (stat.rem_zero) cmd.set_m_big = euc_first;
          else               cmd.euc_step  = 1'b1;
        end
      end
      ST_LCM_PREP: cmd.div_src = DSRC_XY;
      ST_LCM_START: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DSRC_XY;
      end
      ST_LCM_WAIT: begin
        cmd.div_src = DSRC_XY;
        cmd.set_m_q = stat.div_done;
      end
      ST_T1_PREP: cmd.div_src = DSRC_T1;
      ST_T1_START: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DSRC_T1;
      end
      ST_T1_WAIT: begin
        cmd.div_src = DSRC_T1;
        cmd.set_t1  = stat.div_done;
      end
      ST_T2_PREP: cmd.div_src = DSRC_T2;
      ST_T2_START: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DSRC_T2;
      end
      ST_T2_WAIT: begin
        cmd.div_src = DSRC_T2;
        cmd.set_t2  = stat.div_done;
      end
      ST_FIN: cmd.fin_addsub = 1'b1;
      ST_TRN_START: begin
        cmd.div_start = 1'b1;
        cmd.trn_sel   = 1'b1;
      end
      ST_TRN_WAIT: begin
        cmd.trn_sel = 1'b1;
        cmd.fin_trn = stat.div_done;
      end
      ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### rtl/core/rfa_checker.sv
// Port-level checker for the fraction ALU, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none
module rfa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] res_num,
  input wire logic [31:0] res_den,
  input wire logic        error
);
  // One item at a time: no input transfer while a result is offered
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");

  // Error results are all zero
  a_err: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (res_num == 32'd0 && res_den == 32'd0))
    else $error("error result not zero");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(res_num) && $stable(res_den)))
    else $error("stalled result changed");

  // No result directly after an input transfer
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid) else $error("result too early");
endmodule

bind rational_fraction_alu_unit rfa_checker u_rfa_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .res_num(res_num), .res_den(res_den), .error(error)
);
`default_nettype wire

### sim/rational_fraction_alu_unit_chk.sv
// Checker for the rational fraction ALU: watches both channels, predicts
// each result from the accepted operation and compares field by field.
// Depends on rfa_pkg for the operation codes.
module rational_fraction_alu_unit_chk (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [2:0]  kind,
  input  wire logic [31:0] a_num,
  input  wire logic [31:0] a_den,
  input  wire logic [31:0] b_num,
  input  wire logic [31:0] b_den,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [31:0] res_num,
  input  wire logic [31:0] res_den,
  input  wire logic        error,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rfa_pkg::*;

  typedef struct {
    logic [31:0] num;
    logic [31:0] den;
    logic        err;
  } fraction_t;

  fraction_t fraction_q[$];

  // Truncating signed quotient; divisor is nonzero
  function automatic logic [31:0] trunc_quot(logic [31:0] n, logic [31:0] d);
    logic [31:0] mn, md, q;
    mn = n[31] ? -n : n;
    md = d[31] ? -d : d;
    q = mn / md;
    return (n[31] ^ d[31]) ? -q : q;
  endfunction

  // Truncating signed remainder, sign follows the dividend
  function automatic logic [31:0] trunc_rem(logic [31:0] n, logic [31:0] d);
    logic [31:0] mn, md, r;
    mn = n[31] ? -n : n;
    md = d[31] ? -d : d;
    r = mn % md;
    return n[31] ? -r : r;
  endfunction

  // Common multiple of the denominators through the Euclid remainder loop
  function automatic logic [31:0] common_den(logic [31:0] x, logic [31:0] y,
                                             output logic zero_div);
    logic [31:0] diff, big, sml, r;
    diff = x - y;
    zero_div = 1'b0;
    if (diff != 0 && !diff[31]) begin
      big = x;
      sml = y;
    end else begin
      big = y;
      sml = x;
    end
    if (sml == 0) begin
      zero_div = 1'b1;
      return 32'd0;
    end
    r = trunc_rem(big, sml);
    if (r == 0) return big;
    while (r != 0) begin
      big = sml;
      sml = r;
      r = trunc_rem(big, sml);
    end
    return trunc_quot(x * y, sml);
  endfunction

  function automatic fraction_t fraction_op(logic [2:0] k, logic [31:0] an,
                                            logic [31:0] ad, logic [31:0] bn,
                                            logic [31:0] bd);
    fraction_t f;
    logic [31:0] m, t1, t2;
    logic zd;
    f.num = '0;
    f.den = '0;
    f.err = 1'b0;
    case (k) inside
      KIND_ADD, KIND_SUB: begin
        m = common_den(ad, bd, zd);
        if (zd || ad == 0 || bd == 0) begin
          f.err = 1'b1;
        end else begin
          t1 = trunc_quot(m * an, ad);
          t2 = trunc_quot(m * bn, bd);
          f.num = (k == KIND_ADD) ? t1 + t2 : t1 - t2;
          f.den = m;
        end
      end
      KIND_MUL: begin
        f.num = an * bn;
        f.den = ad * bd;
      end
      KIND_DIV: begin
        f.num = an * bd;
        f.den = ad * bn;
      end
      KIND_TRN: begin
        if (ad == 0) begin
          f.err = 1'b1;
        end else begin
          f.num = trunc_quot(an, ad);
          f.den = 32'd1;
        end
      end
      default: ;
    endcase
    return f;
  endfunction

  // Predict on each input transfer, compare on each output transfer
  always @(posedge clk) begin
    fraction_t exp_f;
    if (rst) begin
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (in_valid && !in_stall)
        fraction_q.push_back(fraction_op(kind, a_num, a_den, b_num, b_den));
      if (out_valid && !out_stall) begin
        if (fraction_q.size() == 0) begin
          $display("%0t: unexpected result num=%h den=%h err=%b",
                   $time, res_num, res_den, error);
          fail_count <= fail_count + 1;
        end else begin
          exp_f = fraction_q.pop_front();
          if (res_num !== exp_f.num || res_den !== exp_f.den || error !== exp_f.err) begin
            $display("%0t: mismatch expected num=%h den=%h err=%b, actual num=%h den=%h err=%b",
                     $time, exp_f.num, exp_f.den, exp_f.err, res_num, res_den, error);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= fraction_q.size();
    end
  end
endmodule

### sim/rational_fraction_alu_unit_tb.sv
// Testbench top for the rational fraction ALU: clock, reset, stimulus and
// verdict. Depends on rfa_pkg, the block and rational_fraction_alu_unit_chk.
module rational_fraction_alu_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rfa_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [31:0] MIN_W = 32'h8000_0000;
  localparam logic [31:0] MAX_W = 32'h7fff_ffff;
  localparam logic [31:0] NEG1 = 32'hffff_ffff;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] kind = '0;
  logic [31:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] res_num, res_den;
  logic error;
  int fail_count, pending;
  int send_idle = 0, recv_stall = 0;
  int cycles = 0;

  rational_fraction_alu_unit uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_num(res_num), .res_den(res_den), .error(error)
  );

  rational_fraction_alu_unit_chk chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_num(res_num), .res_den(res_den), .error(error),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall);
  end

  // End the run if it hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Present one operation and hold it until its transfer
  task automatic send_op(logic [2:0] k, logic [31:0] an, logic [31:0] ad,
                         logic [31:0] bn, logic [31:0] bd);
    logic st;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    kind <= k;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    in_valid <= 1'b1;
    forever begin
      @(negedge clk);
      st = in_stall;
      @(posedge clk);
      if (!st) break;
    end
  endtask

  function automatic logic [31:0] rand_word();
    int sel;
    sel = $urandom_range(5);
    case (sel)
      0: return $urandom_range(16) - 8;
      1, 2: return $urandom;
      3: begin
        case ($urandom_range(4))
          0: return MIN_W;
          1: return MAX_W;
          2: return NEG1;
          3: return 32'd1;
          default: return 32'd0;
        endcase
      end
      default: return $urandom_range(1) ? $urandom_range(1000) : -$urandom_range(1000);
    endcase
  endfunction

  function automatic logic [2:0] rand_kind();
    int r;
    r = $urandom_range(19);
    if (r < 19) return r % 5;
    return $urandom_range(7, 5);
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, every operation, zero divisors, unused kinds
    send_op(KIND_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_op(KIND_SUB, 32'd5, 32'd6, 32'd1, 32'd4);
    send_op(KIND_ADD, 32'd3, 32'd7, 32'd2, 32'd7);
    send_op(KIND_ADD, 32'd1, 32'd12, 32'd1, 32'd4);
    send_op(KIND_SUB, 32'd1, 32'd1836311903, 32'd1, 32'd1134903170);
    send_op(KIND_ADD, MAX_W, NEG1, MIN_W, 32'd3);
    send_op(KIND_ADD, 32'd1, 32'd0, 32'd1, 32'd5);
    send_op(KIND_SUB, 32'd1, 32'd5, 32'd1, 32'd0);
    send_op(KIND_ADD, 32'd1, 32'd0, 32'd1, -32'd3);
    send_op(KIND_ADD, 32'd1, MIN_W, 32'd1, MAX_W);
    send_op(KIND_MUL, MAX_W, MIN_W, NEG1, MAX_W);
    send_op(KIND_MUL, 32'd0, 32'd0, 32'd0, 32'd0);
    send_op(KIND_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
    send_op(KIND_DIV, MIN_W, NEG1, MAX_W, MIN_W);
    send_op(KIND_TRN, MIN_W, NEG1, 32'd0, 32'd0);
    send_op(KIND_TRN, -32'd7, 32'd2, 32'd0, 32'd0);
    send_op(KIND_TRN, 32'd7, 32'd0, 32'd1, 32'd1);
    send_op(KIND_TRN, MAX_W, MIN_W, 32'd0, 32'd0);
    send_op(3'd5, MAX_W, 32'd1, 32'd1, 32'd1);
    send_op(3'd6, 32'd1, 32'd1, 32'd1, 32'd1);
    send_op(3'd7, NEG1, NEG1, NEG1, NEG1);

    // Hold off until everything has drained
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);

    // Random phases with different idle and stall rates
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin send_idle = 82; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 82; end
        3: begin send_idle = 38; recv_stall = 38; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      for (int i = 0; i < 60; i++)
        send_op(rand_kind(), rand_word(), rand_word(), rand_word(), rand_word());
    end

    // Drain and give the verdict
    in_valid <= 1'b0;
    recv_stall = 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
